// ===== design/fsp_pkg.sv =====
// fsp_pkg: shared types and constants for the format specifier parser.
// Used by fsp_front, fsp_queue, fsp_back and format_specifier_parser.
package fsp_pkg;

  localparam int MAX_WIDTH_DEF = 509;
  localparam int IN_W          = 40;
  localparam int OUT_W         = 72;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [7:0]  CH_PCT       = 8'h25;
  localparam logic [7:0]  CH_X         = 8'h78;
  localparam logic [7:0]  BAD_CONV     = 8'hFF;
  localparam logic [7:0]  BCNT_MAX     = 8'hFF;
  localparam logic [31:0] PREC_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] PREC_INT_DEF = 32'd1;
  localparam logic [31:0] PREC_FLT_DEF = 32'd6;
  localparam logic [31:0] PREC_HEX_DEF = 32'd13;
  localparam logic [31:0] PREC_PTR     = 32'd8;

  typedef enum logic [2:0] {
    PH_FIRST, PH_FLAGS, PH_STARW, PH_WDIG, PH_PSTART, PH_PDIG, PH_LEN, PH_CONV
  } ph_t;

  typedef enum logic [3:0] {
    LK_NORMAL, LK_CHAR, LK_SHORT, LK_LONG, LK_INTMAX,
    LK_SIZE, LK_PTRDIFF, LK_LLONG, LK_LDOUBLE, LK_WIDE
  } lk_t;

  typedef enum logic [1:0] {J_LEFT, J_RIGHT, J_ZERO} just_t;
  typedef enum logic [1:0] {SG_MINUS, SG_PLUS, SG_SPACE} sign_t;

  typedef enum logic [2:0] {
    FL_NONE, FL_MINUS, FL_PLUS, FL_SPACE, FL_HASH, FL_ZERO, FL_STAR
  } flag_t;

  typedef enum logic [3:0] {
    CV_BAD, CV_INT, CV_FFIX, CV_AHEX, CV_GEN, CV_EXP, CV_PTR, CV_CHR, CV_STR, CV_CNT
  } conv_t;

  typedef struct packed {
    logic       is_digit;
    logic [3:0] dval;
    flag_t      flag;
    logic       is_dot;
    logic       is_pct;
    logic       len_ok;
    lk_t        len;
    conv_t      conv;
  } cls_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic [31:0] arg;
    cls_t        cls;
  } item_t;

  typedef struct packed {
    ph_t         ph;
    just_t       just;
    sign_t       sign;
    logic        pgiven;
    logic        alt;
    lk_t         len;
    logic [31:0] prec;
    logic [7:0]  bcnt;
    logic [1:0]  acnt;
  } pst_t;

  typedef struct packed {
    just_t              just;
    sign_t              sign;
    logic               pgiven;
    logic               alt;
    lk_t                len;
    logic [7:0]         conv;
    logic [8:0]         width;
    logic signed [31:0] prec;
    logic [7:0]         bytes;
    logic [1:0]         args;
  } res_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic fire;
    ph_t  ph;
  } bk_stat_t;

endpackage

// ===== design/fsp_front.sv =====
// fsp_front: accepts input bytes and classifies them for the parse engine.
// Depends on fsp_pkg; writes classified items into fsp_queue.
module fsp_front (
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [fsp_pkg::IN_W-1:0]   in_tdata,
  input  fsp_pkg::q_stat_t           q_stat,
  output logic                       push,
  output fsp_pkg::item_t             item
);

  logic [7:0]    ch;
  fsp_pkg::cls_t c;

  assign ch        = in_tdata[7:0];
  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    c.is_digit = (ch inside {["0":"9"]});
    c.dval     = 4'(ch - "0");
    c.is_dot   = (ch == ".");
    c.is_pct   = (ch == fsp_pkg::CH_PCT);

    case (ch) inside
      "-":     c.flag = fsp_pkg::FL_MINUS;
      "+":     c.flag = fsp_pkg::FL_PLUS;
      " ":     c.flag = fsp_pkg::FL_SPACE;
      "#":     c.flag = fsp_pkg::FL_HASH;
      "0":     c.flag = fsp_pkg::FL_ZERO;
      "*":     c.flag = fsp_pkg::FL_STAR;
      default: c.flag = fsp_pkg::FL_NONE;
    endcase

    c.len_ok = 1'b1;
    case (ch) inside
      "h":     c.len = fsp_pkg::LK_SHORT;
      "l":     c.len = fsp_pkg::LK_LONG;
      "L":     c.len = fsp_pkg::LK_LDOUBLE;
      "j":     c.len = fsp_pkg::LK_INTMAX;
      "z":     c.len = fsp_pkg::LK_SIZE;
      "t":     c.len = fsp_pkg::LK_PTRDIFF;
      default: begin
        c.len    = fsp_pkg::LK_NORMAL;
        c.len_ok = 1'b0;
      end
    endcase

    case (ch) inside
      "d", "i", "o", "u", "x", "X": c.conv = fsp_pkg::CV_INT;
      "f", "F":                     c.conv = fsp_pkg::CV_FFIX;
      "a", "A":                     c.conv = fsp_pkg::CV_AHEX;
      "g", "G":                     c.conv = fsp_pkg::CV_GEN;
      "e", "E":                     c.conv = fsp_pkg::CV_EXP;
      "p":                          c.conv = fsp_pkg::CV_PTR;
      "c":                          c.conv = fsp_pkg::CV_CHR;
      "s":                          c.conv = fsp_pkg::CV_STR;
      "n":                          c.conv = fsp_pkg::CV_CNT;
      default:                      c.conv = fsp_pkg::CV_BAD;
    endcase
  end

  assign item.ch  = ch;
  assign item.arg = in_tdata[39:8];
  assign item.cls = c;

endmodule

// ===== design/fsp_queue.sv =====
// fsp_queue: short FIFO of classified items between front and back.
// Depends on fsp_pkg.
module fsp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fsp_pkg::item_t   push_item,
  input  logic             pop,
  output fsp_pkg::item_t   head,
  output fsp_pkg::q_stat_t q_stat
);

  fsp_pkg::item_t                   mem [fsp_pkg::QDEPTH];
  logic [fsp_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [fsp_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                             do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign head         = mem[rd_ptr_r];
  assign q_stat.count = count_r;
  assign q_stat.full  = (count_r == fsp_pkg::QCNT_W'(fsp_pkg::QDEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

// ===== design/fsp_back.sv =====
// fsp_back: specifier parse engine with result register; one queued byte per cycle unless a result stalls.
// Depends on fsp_pkg; reads items from fsp_queue.
module fsp_back #(
  parameter int MAX_WIDTH = fsp_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fsp_pkg::item_t            head,
  input  fsp_pkg::q_stat_t          q_stat,
  output fsp_pkg::bk_stat_t         bk_stat,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output fsp_pkg::res_t             res
);

  localparam int WW        = $clog2(MAX_WIDTH + 2);
  localparam int WDW       = WW + 4;
  localparam int WIDTH_SAT = MAX_WIDTH + 1;

  fsp_pkg::pst_t   st_r, st_upd, st_nxt, st_clr;
  logic [WW-1:0]   width_r, width_upd, width_nxt;
  fsp_pkg::res_t   res_r, res_nxt;
  logic            out_valid_r;

  fsp_pkg::cls_t   c;
  logic            fire, pop, out_free;
  logic            do_fl, do_aw, do_tl, do_cv, float_bad;
  logic [7:0]      code;
  logic [WDW-1:0]  wd;
  logic [WW-1:0]   wdig_sat, star_sat;
  logic [31:0]     mag;
  logic [35:0]     pd;
  logic [31:0]     pdig_sat;

  assign c = head.cls;

  always_comb begin
    st_clr        = '0;
    st_clr.ph     = fsp_pkg::PH_FIRST;
    st_clr.just   = fsp_pkg::J_RIGHT;
    st_clr.sign   = fsp_pkg::SG_MINUS;
    st_clr.len    = fsp_pkg::LK_NORMAL;
    st_clr.bcnt   = 8'd1;
  end

  // width and precision digit accumulation, star magnitude and float length check
  always_comb begin
    wd       = WDW'(width_r) * WDW'(10) + WDW'(c.dval);
    wdig_sat = (wd > WDW'(WIDTH_SAT)) ? WW'(WIDTH_SAT) : WW'(wd);
    mag      = head.arg[31] ? (32'd0 - head.arg) : head.arg;
    star_sat = (mag > 32'(WIDTH_SAT)) ? WW'(WIDTH_SAT) : WW'(mag);
    pd       = {4'd0, st_r.prec} * 36'd10 + 36'(c.dval);
    pdig_sat = (pd > 36'(fsp_pkg::PREC_MAX)) ? fsp_pkg::PREC_MAX : pd[31:0];
    float_bad = st_r.len inside {fsp_pkg::LK_SHORT, fsp_pkg::LK_INTMAX, fsp_pkg::LK_SIZE,
                                 fsp_pkg::LK_PTRDIFF, fsp_pkg::LK_LLONG, fsp_pkg::LK_CHAR};
  end

  always_comb begin
    st_upd    = st_r;
    width_upd = width_r;
    fire      = 1'b0;
    code      = head.ch;
    do_fl     = 1'b0;
    do_aw     = 1'b0;
    do_tl     = 1'b0;
    do_cv     = 1'b0;
    st_upd.bcnt = (st_r.bcnt == fsp_pkg::BCNT_MAX) ? st_r.bcnt : st_r.bcnt + 8'd1;

    case (st_r.ph)
      fsp_pkg::PH_FIRST: begin
        if (c.is_pct) begin
          fire = 1'b1;
          code = fsp_pkg::CH_PCT;
        end else begin
          do_fl = 1'b1;
        end
      end
      fsp_pkg::PH_FLAGS: do_fl = 1'b1;
      fsp_pkg::PH_STARW: do_aw = 1'b1;
      fsp_pkg::PH_WDIG: begin
        if (c.is_digit) begin
          width_upd = wdig_sat;
        end else begin
          do_aw = 1'b1;
        end
      end
      fsp_pkg::PH_PSTART: begin
        if (c.flag == fsp_pkg::FL_STAR) begin
          st_upd.acnt = st_r.acnt + 2'd1;
          st_upd.prec = head.arg;
          if (head.arg[31]) begin
            st_upd.pgiven = 1'b0;
          end
          st_upd.ph = fsp_pkg::PH_LEN;
        end else if (c.is_digit) begin
          st_upd.prec = pdig_sat;
          st_upd.ph   = fsp_pkg::PH_PDIG;
        end else begin
          do_tl = 1'b1;
        end
      end
      fsp_pkg::PH_PDIG: begin
        if (c.is_digit) begin
          st_upd.prec = pdig_sat;
        end else begin
          do_tl = 1'b1;
        end
      end
      fsp_pkg::PH_LEN: do_tl = 1'b1;
      default: begin
        if (st_r.len == fsp_pkg::LK_SHORT && c.len_ok && c.len == fsp_pkg::LK_SHORT) begin
          st_upd.len = fsp_pkg::LK_CHAR;
        end else if (st_r.len == fsp_pkg::LK_LONG && c.len_ok &&
                     c.len == fsp_pkg::LK_LONG) begin
          st_upd.len = fsp_pkg::LK_LLONG;
        end else begin
          do_cv = 1'b1;
        end
      end
    endcase

    if (do_fl) begin
      case (c.flag)
        fsp_pkg::FL_MINUS: st_upd.just = fsp_pkg::J_LEFT;
        fsp_pkg::FL_PLUS:  st_upd.sign = fsp_pkg::SG_PLUS;
        fsp_pkg::FL_SPACE: begin
          if (st_r.sign != fsp_pkg::SG_PLUS) begin
            st_upd.sign = fsp_pkg::SG_SPACE;
          end
        end
        fsp_pkg::FL_HASH:  st_upd.alt = 1'b1;
        fsp_pkg::FL_ZERO: begin
          if (st_r.just != fsp_pkg::J_LEFT) begin
            st_upd.just = fsp_pkg::J_ZERO;
          end
        end
        fsp_pkg::FL_STAR: begin
          st_upd.acnt = st_r.acnt + 2'd1;
          if (head.arg[31]) begin
            st_upd.just = fsp_pkg::J_LEFT;
          end
          width_upd = star_sat;
          st_upd.ph = fsp_pkg::PH_STARW;
        end
        default: begin
          if (c.is_digit) begin
            width_upd = wdig_sat;
            st_upd.ph = fsp_pkg::PH_WDIG;
          end else begin
            do_aw = 1'b1;
          end
        end
      endcase
      if (st_upd.ph == fsp_pkg::PH_FIRST && !do_aw) begin
        st_upd.ph = fsp_pkg::PH_FLAGS;
      end
    end

    if (do_aw) begin
      if (32'(width_r) > 32'(MAX_WIDTH)) begin
        fire = 1'b1;
        code = fsp_pkg::BAD_CONV;
      end else if (c.is_dot) begin
        st_upd.pgiven = 1'b1;
        st_upd.ph     = fsp_pkg::PH_PSTART;
      end else begin
        do_tl = 1'b1;
      end
    end

    if (do_tl) begin
      if (c.len_ok) begin
        st_upd.len = c.len;
        st_upd.ph  = fsp_pkg::PH_CONV;
      end else begin
        do_cv = 1'b1;
      end
    end

    if (do_cv) begin
      fire = 1'b1;
      case (c.conv)
        fsp_pkg::CV_INT: begin
          if (st_r.len == fsp_pkg::LK_LDOUBLE) begin
            code = fsp_pkg::BAD_CONV;
          end else if (!st_r.pgiven) begin
            st_upd.prec = fsp_pkg::PREC_INT_DEF;
          end else if (st_r.just == fsp_pkg::J_ZERO) begin
            st_upd.just = fsp_pkg::J_RIGHT;
          end
        end
        fsp_pkg::CV_FFIX: begin
          if (st_r.len inside {fsp_pkg::LK_SHORT, [fsp_pkg::LK_INTMAX:fsp_pkg::LK_LLONG]}) begin
            code = fsp_pkg::BAD_CONV;
          end else if (!st_r.pgiven) begin
            st_upd.prec = fsp_pkg::PREC_FLT_DEF;
          end
        end
        fsp_pkg::CV_AHEX: begin
          if (!st_r.pgiven) begin
            st_upd.prec = fsp_pkg::PREC_HEX_DEF;
          end
          if (float_bad) begin
            code = fsp_pkg::BAD_CONV;
          end
        end
        fsp_pkg::CV_GEN, fsp_pkg::CV_EXP: begin
          if (c.conv == fsp_pkg::CV_GEN && st_r.prec == 32'd0) begin
            st_upd.prec = 32'd1;
          end
          if (float_bad) begin
            code = fsp_pkg::BAD_CONV;
          end else if (!st_r.pgiven) begin
            st_upd.prec = fsp_pkg::PREC_FLT_DEF;
          end
        end
        fsp_pkg::CV_PTR: begin
          code        = fsp_pkg::CH_X;
          st_upd.alt  = 1'b1;
          st_upd.len  = fsp_pkg::LK_LONG;
          st_upd.prec = fsp_pkg::PREC_PTR;
        end
        fsp_pkg::CV_CHR: begin
          if (st_r.len == fsp_pkg::LK_LONG) begin
            st_upd.len = fsp_pkg::LK_WIDE;
          end else if (st_r.pgiven || st_r.len != fsp_pkg::LK_NORMAL) begin
            code = fsp_pkg::BAD_CONV;
          end
        end
        fsp_pkg::CV_STR: begin
          if (st_r.len == fsp_pkg::LK_LONG) begin
            st_upd.len = fsp_pkg::LK_WIDE;
          end else if (st_r.len != fsp_pkg::LK_NORMAL) begin
            code = fsp_pkg::BAD_CONV;
          end
        end
        fsp_pkg::CV_CNT: begin
          if (st_r.len == fsp_pkg::LK_LDOUBLE) begin
            code = fsp_pkg::BAD_CONV;
          end
        end
        default: code = fsp_pkg::BAD_CONV;
      endcase
    end

    res_nxt.just   = st_upd.just;
    res_nxt.sign   = st_upd.sign;
    res_nxt.pgiven = st_upd.pgiven;
    res_nxt.alt    = st_upd.alt;
    res_nxt.len    = st_upd.len;
    res_nxt.conv   = code;
    res_nxt.width  = (32'(width_upd) > 32'd511) ? 9'd511 : 9'(width_upd);
    res_nxt.prec   = st_upd.prec;
    res_nxt.bytes  = st_upd.bcnt;
    res_nxt.args   = st_upd.acnt;

    st_nxt    = fire ? st_clr : st_upd;
    width_nxt = fire ? '0 : width_upd;
  end

  assign out_free = !out_valid_r || out_tready;
  assign pop      = !q_stat.empty && (!fire || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= st_clr;
      width_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        st_r    <= st_nxt;
        width_r <= width_nxt;
      end
      if (out_free) begin
        out_valid_r <= pop && fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pop && fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign res          = res_r;
  assign bk_stat.pop  = pop;
  assign bk_stat.fire = fire;
  assign bk_stat.ph   = st_r.ph;

endmodule

// ===== design/format_specifier_parser.sv =====
// format_specifier_parser: printf conversion specifier decoder, one byte per transfer.
// out_tvalid is registered: the byte that ends a specifier is queued, then popped by the parse engine.
// Throughput: 1 byte per cycle while no result waits on out_tready.
// A 2-entry queue lets input transfers continue while a result waits on out_tready.
// Reset: rst_n synchronous, active low; clears parse state, queue and out_tvalid.
// Depends on fsp_pkg, fsp_front, fsp_queue, fsp_back.
module format_specifier_parser #(
  parameter int MAX_WIDTH = fsp_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [fsp_pkg::IN_W-1:0]   in_tdata,   // char_in[7:0], arg_value[39:8]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [fsp_pkg::OUT_W-1:0]  out_tdata   // justify_mode[1:0], sign_mode[3:2],
                                                 // precision_given[4], alt_form[5],
                                                 // length_kind[9:6], conv_code[17:10],
                                                 // width_out[26:18], precision_out[58:27],
                                                 // bytes_used[66:59], args_used[68:67]
);

  fsp_pkg::q_stat_t  q_stat;
  fsp_pkg::bk_stat_t bk_stat;
  fsp_pkg::item_t    push_item, head;
  fsp_pkg::res_t     res;
  logic              push;

  fsp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .item      (push_item)
  );

  fsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (bk_stat.pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  fsp_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .bk_stat    (bk_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res        (res)
  );

  assign out_tdata = {3'b000, res.args, res.bytes, res.prec, res.width, res.conv,
                      4'(res.len), res.alt, res.pgiven, 2'(res.sign), 2'(res.just)};

`ifndef SYNTH
  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop && bk_stat.fire |=> bk_stat.ph == fsp_pkg::PH_FIRST)
    else $error("parse state not cleared after result");

  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    push && !bk_stat.pop |=> q_stat.count == $past(q_stat.count) + 1'b1)
    else $error("queue count did not follow push");

  a_result_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.bytes >= 8'd2 && res.args != 2'd3)
    else $error("result byte or argument count out of range");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for format_specifier_parser: specifier bytes in, decoded formats out.
// A scoreboard class tracks the parse state and checks each format field by field.
// Depends on fsp_pkg and the format_specifier_parser RTL.
`timescale 1ns / 1ps

module tb;
  import fsp_pkg::*;

  localparam int WIDTH_SAT = MAX_WIDTH_DEF + 1;

  typedef struct {
    logic [1:0]  just;
    logic [1:0]  sgn;
    logic        pgiven;
    logic        alt;
    logic [3:0]  len;
    logic [7:0]  conv;
    logic [8:0]  wid;
    logic [31:0] prec;
    logic [7:0]  bytes;
    logic [1:0]  args;
  } spec_fmt_t;

  class spec_scoreboard;
    ph_t         ph;
    just_t       just;
    sign_t       sgn;
    logic        pgiven;
    logic        alt;
    lk_t         len;
    logic [9:0]  wid;
    logic [31:0] prec;
    logic [7:0]  bcnt;
    logic [1:0]  acnt;
    spec_fmt_t   formats_due[$];
    int          errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph     = PH_FIRST;
      just   = J_RIGHT;
      sgn    = SG_MINUS;
      pgiven = 1'b0;
      alt    = 1'b0;
      len    = LK_NORMAL;
      wid    = '0;
      prec   = '0;
      bcnt   = 8'd1;
      acnt   = '0;
    endfunction

    function bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void close_spec(logic [7:0] code);
      spec_fmt_t f;
      f.just   = just;
      f.sgn    = sgn;
      f.pgiven = pgiven;
      f.alt    = alt;
      f.len    = len;
      f.conv   = code;
      f.wid    = (wid > 10'd511) ? 9'd511 : wid[8:0];
      f.prec   = prec;
      f.bytes  = bcnt;
      f.args   = acnt;
      formats_due.push_back(f);
      clear();
    endfunction

    function bit float_bad_len();
      return len == LK_SHORT || len == LK_INTMAX || len == LK_SIZE ||
             len == LK_PTRDIFF || len == LK_LLONG || len == LK_CHAR;
    endfunction

    function void convert(logic [7:0] c);
      logic [7:0] code;
      code = c;
      case (c)
        "d", "i", "o", "u", "x", "X": begin
          if (len == LK_LDOUBLE) code = BAD_CONV;
          else if (!pgiven) prec = PREC_INT_DEF;
          else if (just == J_ZERO) just = J_RIGHT;
        end
        "f", "F": begin
          if (len == LK_SHORT || (len >= LK_INTMAX && len <= LK_LLONG)) code = BAD_CONV;
          else if (!pgiven) prec = PREC_FLT_DEF;
        end
        "a", "A": begin
          if (!pgiven) prec = PREC_HEX_DEF;
          if (float_bad_len()) code = BAD_CONV;
        end
        "g", "G", "e", "E": begin
          if ((c == "g" || c == "G") && prec == 32'd0) prec = 32'd1;
          if (float_bad_len()) code = BAD_CONV;
          else if (!pgiven) prec = PREC_FLT_DEF;
        end
        "p": begin
          code = CH_X;
          alt  = 1'b1;
          len  = LK_LONG;
          prec = PREC_PTR;
        end
        "c": begin
          if (len == LK_LONG) len = LK_WIDE;
          else if (pgiven || len != LK_NORMAL) code = BAD_CONV;
        end
        "s": begin
          if (len == LK_LONG) len = LK_WIDE;
          else if (len != LK_NORMAL) code = BAD_CONV;
        end
        "n": if (len == LK_LDOUBLE) code = BAD_CONV;
        default: code = BAD_CONV;
      endcase
      close_spec(code);
    endfunction

    function void take_length(logic [7:0] c);
      case (c)
        "h": len = LK_SHORT;
        "l": len = LK_LONG;
        "L": len = LK_LDOUBLE;
        "j": len = LK_INTMAX;
        "z": len = LK_SIZE;
        "t": len = LK_PTRDIFF;
        default: begin
          convert(c);
          return;
        end
      endcase
      ph = PH_CONV;
    endfunction

    function void after_width(logic [7:0] c);
      if (wid > MAX_WIDTH_DEF) begin
        close_spec(BAD_CONV);
      end else if (c == ".") begin
        pgiven = 1'b1;
        ph     = PH_PSTART;
      end else begin
        take_length(c);
      end
    endfunction

    function void width_digit(logic [7:0] c);
      int unsigned w;
      w   = wid * 10 + (c - "0");
      wid = (w > WIDTH_SAT) ? 10'(WIDTH_SAT) : w[9:0];
      ph  = PH_WDIG;
    endfunction

    function void prec_digit(logic [7:0] c);
      logic [31:0] d;
      d = 32'(c - "0");
      if (prec > (PREC_MAX - d) / 10) prec = PREC_MAX;
      else prec = prec * 10 + d;
      ph = PH_PDIG;
    endfunction

    function void flag_byte(logic [7:0] c, logic [31:0] arg);
      logic [31:0] mag;
      case (c)
        "-": just = J_LEFT;
        "+": sgn = SG_PLUS;
        " ": if (sgn != SG_PLUS) sgn = SG_SPACE;
        "#": alt = 1'b1;
        "0": if (just != J_LEFT) just = J_ZERO;
        "*": begin
          mag  = arg;
          acnt = acnt + 2'd1;
          if (arg[31]) begin
            just = J_LEFT;
            mag  = 32'd0 - arg;
          end
          wid = (mag > WIDTH_SAT) ? 10'(WIDTH_SAT) : mag[9:0];
          ph  = PH_STARW;
        end
        default: begin
          if (is_dig(c)) begin
            width_digit(c);
          end else begin
            after_width(c);
            return;
          end
        end
      endcase
      if (ph == PH_FIRST) ph = PH_FLAGS;
    endfunction

    // one accepted input transfer
    function void note_byte(logic [7:0] c, logic [31:0] arg);
      if (bcnt < BCNT_MAX) bcnt = bcnt + 8'd1;
      case (ph)
        PH_FIRST: begin
          if (c == CH_PCT) close_spec(CH_PCT);
          else flag_byte(c, arg);
        end
        PH_FLAGS: flag_byte(c, arg);
        PH_STARW: after_width(c);
        PH_WDIG: begin
          if (is_dig(c)) width_digit(c);
          else after_width(c);
        end
        PH_PSTART: begin
          if (c == "*") begin
            acnt = acnt + 2'd1;
            prec = arg;
            if (arg[31]) pgiven = 1'b0;
            ph = PH_LEN;
          end else if (is_dig(c)) begin
            prec_digit(c);
          end else begin
            take_length(c);
          end
        end
        PH_PDIG: begin
          if (is_dig(c)) prec_digit(c);
          else take_length(c);
        end
        PH_LEN: take_length(c);
        default: begin
          if (len == LK_SHORT && c == "h") len = LK_CHAR;
          else if (len == LK_LONG && c == "l") len = LK_LLONG;
          else convert(c);
        end
      endcase
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // one accepted output transfer
    function void check_format(logic [OUT_W-1:0] d);
      spec_fmt_t want;
      if (formats_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected format, expected none, actual %h", $time, d);
        return;
      end
      want = formats_due.pop_front();
      cmp_field("justify_mode", want.just, d[1:0]);
      cmp_field("sign_mode", want.sgn, d[3:2]);
      cmp_field("precision_given", want.pgiven, d[4]);
      cmp_field("alt_form", want.alt, d[5]);
      cmp_field("length_kind", want.len, d[9:6]);
      cmp_field("conv_code", want.conv, d[17:10]);
      cmp_field("width_out", want.wid, d[26:18]);
      cmp_field("precision_out", want.prec, d[58:27]);
      cmp_field("bytes_used", want.bytes, d[66:59]);
      cmp_field("args_used", want.args, d[68:67]);
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;

  spec_scoreboard sb = new();

  logic [7:0]  spec_bytes[$];
  logic [31:0] spec_args[$];
  int          sent = 0;
  bit          snd_burst = 1'b0;
  bit          rdy_burst = 1'b0;

  always #2 clk = ~clk;

  format_specifier_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_format(out_tdata);
  end

  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rdy_burst = !rdy_burst;
      stall = rdy_burst ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  task automatic push_byte(logic [7:0] c);
    spec_bytes.push_back(c);
    spec_args.push_back($urandom);
  endtask

  task automatic push_star(logic [31:0] arg);
    spec_bytes.push_back("*");
    spec_args.push_back(arg);
  endtask

  task automatic push_digit();
    push_byte(8'("0" + $urandom_range(0, 9)));
  endtask

  task automatic push_text(string s);
    foreach (s[i]) push_byte(s[i]);
  endtask

  function automatic logic [31:0] star_arg();
    case ($urandom_range(0, 6))
      0: return $urandom_range(0, 20);
      1: return 32'd0 - $urandom_range(1, 20);
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(495, 525);
      5: return 32'd0 - $urandom_range(495, 525);
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed specifiers with random content, some raw noise
  task automatic build_random();
    string flag_chars;
    string convs;
    flag_chars = "-+ #0";
    convs      = "diouxXfFaAgGeEpcsn";
    case ($urandom_range(0, 19))
      0: begin
        push_byte(CH_PCT);
        return;
      end
      1, 2: begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
        return;
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 3)) push_byte(flag_chars[$urandom_range(0, 4)]);
    case ($urandom_range(0, 9))
      3, 4:    push_star(star_arg());
      5, 6, 7: repeat ($urandom_range(1, 2)) push_digit();
      8:       push_text($sformatf("%0d", $urandom_range(495, 525)));
      9:       repeat ($urandom_range(4, 6)) push_digit();
      default: ;
    endcase
    case ($urandom_range(0, 9))
      4: push_byte(".");
      5, 6: begin
        push_byte(".");
        push_star(star_arg());
      end
      7: begin
        push_byte(".");
        repeat ($urandom_range(1, 3)) push_digit();
      end
      8: begin
        push_byte(".");
        repeat ($urandom_range(9, 12)) push_digit();
      end
      9: begin
        push_byte(".");
        push_text($sformatf("%0d", 64'd2147483640 + $urandom_range(0, 15)));
      end
      default: ;
    endcase
    case ($urandom_range(0, 11))
      4:  push_byte("h");
      5:  push_text("hh");
      6:  push_byte("l");
      7:  push_text("ll");
      8:  push_byte("L");
      9:  push_byte("j");
      10: push_byte("z");
      11: push_byte("t");
      default: ;
    endcase
    if ($urandom_range(0, 11) == 0) push_byte(8'($urandom_range(0, 255)));
    else push_byte(convs[$urandom_range(0, convs.len() - 1)]);
  endtask

  task automatic send_byte(logic [7:0] c, logic [31:0] arg, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {arg, c};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_byte(c, arg);
    sent++;
  endtask

  task automatic send_all();
    while (spec_bytes.size() != 0) begin
      if ($urandom_range(0, 39) == 0) snd_burst = !snd_burst;
      send_byte(spec_bytes.pop_front(), spec_args.pop_front(),
                snd_burst ? 0 : $urandom_range(0, 14));
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.formats_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int next_drain;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    push_byte(CH_PCT);
    push_star(32'h8000_0000);
    push_byte("d");
    push_text("+ #0");
    push_star(32'd0 - 32'd5);
    push_byte(".");
    push_star(32'd0 - 32'd3);
    push_text("lld");
    push_text("600x");
    push_text("hhf");
    push_byte("p");
    push_byte(8'hC8);
    send_all();
    drain();

    // long precision: digit saturation and byte count saturation
    push_byte(".");
    repeat (270) push_digit();
    push_byte("u");
    send_all();

    next_drain = sent + 300;
    while (sent < 950) begin
      build_random();
      send_all();
      if (sent >= next_drain) begin
        drain();
        next_drain = sent + 300;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
